### hdl/ast_pkg.sv
// ast_pkg: shared constants, command and status codes and the result record
// for the array set toggle store. No dependencies.
package ast_pkg;

  // Default configuration handed to the top level
  localparam int CAPACITY_DEF = 32;
  localparam int KEY_BITS_DEF = 31;

  // Port field widths
  localparam int CMD_W    = 2;
  localparam int KEY_W    = 31;
  localparam int RIDX_W   = 5;
  localparam int STATUS_W = 3;
  localparam int POS_W    = 5;
  localparam int COUNT_W  = 6;

  // Command codes (the unused code behaves as a read)
  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_TOGGLE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ   = 2'd2;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd0;
  localparam logic [STATUS_W-1:0] ST_REMOVED  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_PRESENT  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd3;
  localparam logic [STATUS_W-1:0] ST_READ_OK  = 3'd4;
  localparam logic [STATUS_W-1:0] ST_READ_OOR = 3'd5;

  // One result as handed from the sequencer to the output register
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [POS_W-1:0]    position;
    logic [KEY_W-1:0]    entry_key;
    logic [COUNT_W-1:0]  entry_count;
  } res_t;

endpackage

### hdl/ast_key_ram.sv
// ast_key_ram: key storage, one write and one registered read per cycle.
// No package dependencies.
module ast_key_ram #(
  parameter int DEPTH = 32,
  parameter int WIDTH = 31
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### hdl/ast_seq.sv
// ast_seq: command sequencer for the array set toggle store. Walks the key
// RAM for search and shift-down, keeps the fill count. Uses ast_pkg.
module ast_seq #(
  parameter int CAPACITY = ast_pkg::CAPACITY_DEF,
  parameter int KEY_BITS = ast_pkg::KEY_BITS_DEF,
  localparam int IDX_W = $clog2(CAPACITY),
  localparam int CNT_W = $clog2(CAPACITY + 1)
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // command side
  input  logic                         in_valid,
  input  logic [ast_pkg::CMD_W-1:0]    in_cmd,
  input  logic [ast_pkg::KEY_W-1:0]    in_key,
  input  logic [ast_pkg::RIDX_W-1:0]   in_read_index,
  output logic                         idle,
  // result side
  output logic                         res_valid,
  output ast_pkg::res_t                res,
  input  logic                         res_ready,
  // key RAM
  output logic                         ram_we,
  output logic [IDX_W-1:0]             ram_waddr,
  output logic [KEY_BITS-1:0]          ram_wdata,
  output logic [IDX_W-1:0]             ram_raddr,
  input  logic [KEY_BITS-1:0]          ram_rdata
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SEARCH = 3'd1;
  localparam logic [2:0] S_APPEND = 3'd2;
  localparam logic [2:0] S_SHIFT  = 3'd3;
  localparam logic [2:0] S_RDWAIT = 3'd4;
  localparam logic [2:0] S_DONE   = 3'd5;

  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  logic [2:0]                  state_r, state_nxt;
  logic [ast_pkg::CMD_W-1:0]   cmd_r, cmd_nxt;
  logic [KEY_BITS-1:0]         key_r, key_nxt;
  logic [CNT_W-1:0]            cnt_r, cnt_nxt;
  logic [IDX_W-1:0]            scan_r, scan_nxt;
  logic                        scan_left_r, scan_left_nxt;
  logic                        cmp_vld_r, cmp_vld_nxt;
  logic [IDX_W-1:0]            cmp_idx_r, cmp_idx_nxt;
  logic [IDX_W-1:0]            hit_r, hit_nxt;
  logic [CNT_W-1:0]            rp_r, rp_nxt;
  logic                        rp_left_r, rp_left_nxt;
  logic                        wr_vld_r, wr_vld_nxt;
  logic [IDX_W-1:0]            wa_r, wa_nxt;
  ast_pkg::res_t               res_r, res_nxt;

  // widened views used for width-safe conversions
  logic [KEY_BITS+ast_pkg::KEY_W-1:0] key_in_w;
  logic [KEY_BITS+ast_pkg::KEY_W-1:0] key_out_w;
  logic [KEY_BITS-1:0]                key_in_m;
  logic [CNT_W+ast_pkg::RIDX_W-1:0]   ridx_w;
  logic [CNT_W+ast_pkg::RIDX_W-1:0]   cnt_w;
  logic [CNT_W-1:0]                   cnt_dec;
  logic [CNT_W-1:0]                   hit_inc;
  logic [CNT_W-1:0]                   rp_inc;
  logic [CNT_W-1:0]                   rp_dec;
  logic                               is_search_cmd;
  logic                               key_hit;

  function automatic logic [ast_pkg::POS_W-1:0] idx_pos(input logic [IDX_W-1:0] i);
    logic [IDX_W+ast_pkg::POS_W-1:0] w;
    w = {{ast_pkg::POS_W{1'b0}}, i};
    return w[ast_pkg::POS_W-1:0];
  endfunction

  function automatic logic [ast_pkg::POS_W-1:0] cnt_pos(input logic [CNT_W-1:0] c);
    logic [CNT_W+ast_pkg::POS_W-1:0] w;
    w = {{ast_pkg::POS_W{1'b0}}, c};
    return w[ast_pkg::POS_W-1:0];
  endfunction

  function automatic logic [ast_pkg::COUNT_W-1:0] cnt_field(input logic [CNT_W-1:0] c);
    logic [CNT_W+ast_pkg::COUNT_W-1:0] w;
    w = {{ast_pkg::COUNT_W{1'b0}}, c};
    return w[ast_pkg::COUNT_W-1:0];
  endfunction

  // width conversions
  assign key_in_w      = {{KEY_BITS{1'b0}}, in_key};
  assign key_in_m      = key_in_w[KEY_BITS-1:0];
  assign key_out_w     = {{ast_pkg::KEY_W{1'b0}}, ram_rdata};
  assign ridx_w        = {{CNT_W{1'b0}}, in_read_index};
  assign cnt_w         = {{ast_pkg::RIDX_W{1'b0}}, cnt_r};
  assign cnt_dec       = cnt_r - 1'b1;
  assign hit_inc       = {{(CNT_W-IDX_W){1'b0}}, cmp_idx_r} + 1'b1;
  assign rp_inc        = rp_r + 1'b1;
  assign rp_dec        = rp_r - 1'b1;
  assign is_search_cmd = (in_cmd == ast_pkg::CMD_INSERT) || (in_cmd == ast_pkg::CMD_TOGGLE);
  // the shared comparator
  assign key_hit       = cmp_vld_r && (ram_rdata == key_r);

  // sequencer next state
  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    key_nxt       = key_r;
    cnt_nxt       = cnt_r;
    scan_nxt      = scan_r;
    scan_left_nxt = scan_left_r;
    cmp_vld_nxt   = 1'b0;
    cmp_idx_nxt   = cmp_idx_r;
    hit_nxt       = hit_r;
    rp_nxt        = rp_r;
    rp_left_nxt   = rp_left_r;
    wr_vld_nxt    = 1'b0;
    wa_nxt        = wa_r;
    res_nxt       = res_r;
    ram_we        = 1'b0;
    ram_waddr     = wa_r;
    ram_wdata     = ram_rdata;
    ram_raddr     = scan_r;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd_nxt               = in_cmd;
          key_nxt               = key_in_m;
          res_nxt.entry_key     = '0;
          res_nxt.position      = '0;
          if (is_search_cmd) begin
            scan_nxt      = cnt_dec[IDX_W-1:0];
            scan_left_nxt = 1'b1;
            state_nxt     = (cnt_r == '0) ? S_APPEND : S_SEARCH;
          end else begin
            res_nxt.position = in_read_index;
            if (ridx_w < cnt_w) begin
              ram_raddr      = ridx_w[IDX_W-1:0];
              res_nxt.status = ast_pkg::ST_READ_OK;
              state_nxt      = S_RDWAIT;
            end else begin
              res_nxt.status = ast_pkg::ST_READ_OOR;
              state_nxt      = S_DONE;
            end
          end
        end
      end

      // backward scan: address issued in the cycle before its compare
      S_SEARCH: begin
        if (scan_left_r) begin
          ram_raddr   = scan_r;
          cmp_vld_nxt = 1'b1;
          cmp_idx_nxt = scan_r;
          if (scan_r == '0) begin
            scan_left_nxt = 1'b0;
          end else begin
            scan_nxt = scan_r - 1'b1;
          end
        end
        if (key_hit) begin
          cmp_vld_nxt = 1'b0;
          if (cmd_r == ast_pkg::CMD_INSERT) begin
            res_nxt.status   = ast_pkg::ST_PRESENT;
            res_nxt.position = idx_pos(cmp_idx_r);
            state_nxt        = S_DONE;
          end else begin
            hit_nxt     = cmp_idx_r;
            rp_nxt      = hit_inc;
            rp_left_nxt = (hit_inc < cnt_r);
            state_nxt   = S_SHIFT;
          end
        end else if (cmp_vld_r && (cmp_idx_r == '0)) begin
          cmp_vld_nxt = 1'b0;
          state_nxt   = S_APPEND;
        end
      end

      // key absent: append at the tail if there is room
      S_APPEND: begin
        if (cnt_r == CAP_CNT) begin
          res_nxt.status   = ast_pkg::ST_FULL;
          res_nxt.position = '0;
        end else begin
          ram_we           = 1'b1;
          ram_waddr        = cnt_r[IDX_W-1:0];
          ram_wdata        = key_r;
          cnt_nxt          = cnt_r + 1'b1;
          res_nxt.status   = ast_pkg::ST_INSERTED;
          res_nxt.position = cnt_pos(cnt_r);
        end
        state_nxt = S_DONE;
      end

      // removal: move each later entry down one place, read ahead of write
      S_SHIFT: begin
        if (wr_vld_r) begin
          ram_we    = 1'b1;
          ram_waddr = wa_r;
          ram_wdata = ram_rdata;
        end
        if (rp_left_r) begin
          ram_raddr   = rp_r[IDX_W-1:0];
          wa_nxt      = rp_dec[IDX_W-1:0];
          wr_vld_nxt  = 1'b1;
          rp_nxt      = rp_inc;
          rp_left_nxt = (rp_inc < cnt_r);
        end else if (!wr_vld_r) begin
          cnt_nxt          = cnt_dec;
          res_nxt.status   = ast_pkg::ST_REMOVED;
          res_nxt.position = idx_pos(hit_r);
          state_nxt        = S_DONE;
        end
      end

      S_RDWAIT: begin
        res_nxt.entry_key = key_out_w[ast_pkg::KEY_W-1:0];
        state_nxt         = S_DONE;
      end

      S_DONE: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      scan_left_r <= 1'b0;
      cmp_vld_r   <= 1'b0;
      rp_left_r   <= 1'b0;
      wr_vld_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      scan_left_r <= scan_left_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      rp_left_r   <= rp_left_nxt;
      wr_vld_r    <= wr_vld_nxt;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    cmd_r     <= cmd_nxt;
    key_r     <= key_nxt;
    scan_r    <= scan_nxt;
    cmp_idx_r <= cmp_idx_nxt;
    hit_r     <= hit_nxt;
    rp_r      <= rp_nxt;
    wa_r      <= wa_nxt;
    res_r     <= res_nxt;
  end

  assign idle      = (state_r == S_IDLE);
  assign res_valid = (state_r == S_DONE);

  // count reported is the one left after the item
  always_comb begin
    res             = res_r;
    res.entry_count = cnt_field(cnt_r);
  end

endmodule

### hdl/array_set_toggle_store.sv
// array_set_toggle_store: top level, sequencer, key RAM and output register.
// Uses ast_pkg, ast_seq and ast_key_ram.
//
// Keeps up to CAPACITY distinct keys in arrival order in a key RAM with one
// write port and one registered read port, walked one entry per cycle by a
// small sequencer with one shared key comparator. Items are taken one at a
// time; in_stall is high while an item is in work. A read out of range is
// answered without reading the RAM. An insert or a toggle scans the stored
// keys backward from the newest; if its key is absent it is appended at the
// tail, or rejected when the store is full. An insert that finds its key at
// index h stops there; a toggle that finds it removes it and shifts each
// later entry down one place. A stall on the result side that keeps the
// output register full holds the sequencer in its done state. The result is
// held in an output register, so the next item is taken while a finished
// result still waits. No clearing pass after reset: only entries below the
// fill count are ever read.
module array_set_toggle_store #(
  parameter int CAPACITY = ast_pkg::CAPACITY_DEF,
  parameter int KEY_BITS = ast_pkg::KEY_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [ast_pkg::CMD_W-1:0]       in_cmd,
  input  logic [ast_pkg::KEY_W-1:0]       in_key,
  input  logic [ast_pkg::RIDX_W-1:0]      in_read_index,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [ast_pkg::STATUS_W-1:0]    out_status,
  output logic [ast_pkg::POS_W-1:0]       out_position,
  output logic [ast_pkg::KEY_W-1:0]       out_entry_key,
  output logic [ast_pkg::COUNT_W-1:0]     out_entry_count
);

  localparam int IDX_W = $clog2(CAPACITY);

  logic                seq_idle;
  logic                res_valid;
  logic                res_ready;
  ast_pkg::res_t       res;
  logic                ram_we;
  logic [IDX_W-1:0]    ram_waddr;
  logic [KEY_BITS-1:0] ram_wdata;
  logic [IDX_W-1:0]    ram_raddr;
  logic [KEY_BITS-1:0] ram_rdata;
  logic                out_valid_r, out_valid_nxt;
  ast_pkg::res_t       out_r;
  logic                out_load;

  ast_seq #(
    .CAPACITY (CAPACITY),
    .KEY_BITS (KEY_BITS)
  ) u_seq (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_cmd        (in_cmd),
    .in_key        (in_key),
    .in_read_index (in_read_index),
    .idle          (seq_idle),
    .res_valid     (res_valid),
    .res           (res),
    .res_ready     (res_ready),
    .ram_we        (ram_we),
    .ram_waddr     (ram_waddr),
    .ram_wdata     (ram_wdata),
    .ram_raddr     (ram_raddr),
    .ram_rdata     (ram_rdata)
  );

  ast_key_ram #(
    .DEPTH (CAPACITY),
    .WIDTH (KEY_BITS)
  ) u_key_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_stall = !seq_idle;

  // output register: loads when empty or when its result is transferred
  assign res_ready = !out_valid_r || !out_stall;
  assign out_load  = res_valid && res_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_r <= res;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_r.status;
  assign out_position    = out_r.position;
  assign out_entry_key   = out_r.entry_key;
  assign out_entry_count = out_r.entry_count;

endmodule

### tb/sv/tb_top.sv
// tb_top: self-checking testbench for array_set_toggle_store.
// Depends on ast_pkg and the array_set_toggle_store RTL; runs a directed table, then
// random command bursts, checking each result against a typed row or a software key set.
module tb_top;

  localparam int NUM_DIRECTED = 17;
  localparam int NUM_RANDOM   = 533;
  localparam int WATCHDOG_MAX = 3000;
  localparam int DRAIN_CYCLES = 80;
  localparam logic [ast_pkg::CMD_W-1:0] CMD_SPARE = 2'd3;  // unused code, behaves as read

  localparam int MODE_FILL  = 0;
  localparam int MODE_DRAIN = 1;
  localparam int MODE_MIX   = 2;

  typedef struct packed {
    logic [ast_pkg::CMD_W-1:0]  cmd;
    logic [ast_pkg::KEY_W-1:0]  key;
    logic [ast_pkg::RIDX_W-1:0] ridx;
    logic                       typed;  // expected result given in the row
    ast_pkg::res_t              res;
  } stim_row_t;

  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         in_valid = 1'b0;
  logic                         in_stall;
  logic [ast_pkg::CMD_W-1:0]    in_cmd = ast_pkg::CMD_INSERT;
  logic [ast_pkg::KEY_W-1:0]    in_key = '0;
  logic [ast_pkg::RIDX_W-1:0]   in_read_index = '0;
  logic                         out_valid;
  logic                         out_stall = 1'b0;
  logic [ast_pkg::STATUS_W-1:0] out_status;
  logic [ast_pkg::POS_W-1:0]    out_position;
  logic [ast_pkg::KEY_W-1:0]    out_entry_key;
  logic [ast_pkg::COUNT_W-1:0]  out_entry_count;

  // Software copy of the key set
  logic [ast_pkg::KEY_W-1:0] set_keys [ast_pkg::CAPACITY_DEF];
  int                        set_count = 0;

  ast_pkg::res_t pending_results [$];
  int            fail_count = 0;
  int            quiet_cycles = 0;
  bit            no_idle = 1'b0;

  // Directed table: extremes, every command, removal shift, boundaries
  stim_row_t directed_rows [NUM_DIRECTED] = '{
    '{ast_pkg::CMD_READ,   31'h0,        5'd0,  1'b1,
      '{ast_pkg::ST_READ_OOR, 5'd0,  31'h0,        6'd0}},
    '{ast_pkg::CMD_READ,   31'h7FFFFFFF, 5'd31, 1'b1,
      '{ast_pkg::ST_READ_OOR, 5'd31, 31'h0,        6'd0}},
    '{ast_pkg::CMD_INSERT, 31'h0,        5'd31, 1'b1,
      '{ast_pkg::ST_INSERTED, 5'd0,  31'h0,        6'd1}},
    '{ast_pkg::CMD_INSERT, 31'h7FFFFFFF, 5'd0,  1'b1,
      '{ast_pkg::ST_INSERTED, 5'd1,  31'h0,        6'd2}},
    '{ast_pkg::CMD_INSERT, 31'h0,        5'd0,  1'b1,
      '{ast_pkg::ST_PRESENT,  5'd0,  31'h0,        6'd2}},
    '{ast_pkg::CMD_INSERT, 31'h7FFFFFFF, 5'd0,  1'b1,
      '{ast_pkg::ST_PRESENT,  5'd1,  31'h0,        6'd2}},
    '{ast_pkg::CMD_READ,   31'h0,        5'd1,  1'b1,
      '{ast_pkg::ST_READ_OK,  5'd1,  31'h7FFFFFFF, 6'd2}},
    '{CMD_SPARE,           31'h55555555, 5'd0,  1'b1,
      '{ast_pkg::ST_READ_OK,  5'd0,  31'h0,        6'd2}},
    '{ast_pkg::CMD_TOGGLE, 31'h2AAAAAAA, 5'd0,  1'b1,
      '{ast_pkg::ST_INSERTED, 5'd2,  31'h0,        6'd3}},
    '{ast_pkg::CMD_TOGGLE, 31'h0,        5'd0,  1'b1,
      '{ast_pkg::ST_REMOVED,  5'd0,  31'h0,        6'd2}},
    '{ast_pkg::CMD_READ,   31'h0,        5'd0,  1'b0, '0},
    '{ast_pkg::CMD_READ,   31'h0,        5'd1,  1'b0, '0},
    '{ast_pkg::CMD_READ,   31'h0,        5'd2,  1'b1,
      '{ast_pkg::ST_READ_OOR, 5'd2,  31'h0,        6'd2}},
    '{ast_pkg::CMD_TOGGLE, 31'h2AAAAAAA, 5'd0,  1'b0, '0},
    '{ast_pkg::CMD_TOGGLE, 31'h7FFFFFFF, 5'd0,  1'b1,
      '{ast_pkg::ST_REMOVED,  5'd0,  31'h0,        6'd0}},
    '{ast_pkg::CMD_TOGGLE, 31'h12345678, 5'd0,  1'b0, '0},
    '{CMD_SPARE,           31'h7FFFFFFF, 5'd31, 1'b0, '0}
  };

  array_set_toggle_store DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_cmd          (in_cmd),
    .in_key          (in_key),
    .in_read_index   (in_read_index),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_position    (out_position),
    .out_entry_key   (out_entry_key),
    .out_entry_count (out_entry_count)
  );

  always #5 clk = ~clk;

  // Applies one command to the key set and returns the result it should give
  function automatic ast_pkg::res_t apply_to_set(logic [ast_pkg::CMD_W-1:0] cmd,
                                                 logic [ast_pkg::KEY_W-1:0] key,
                                                 logic [ast_pkg::RIDX_W-1:0] ridx);
    ast_pkg::res_t r;
    int            hit;
    int            i;
    r = '0;
    hit = -1;
    if (cmd == ast_pkg::CMD_INSERT || cmd == ast_pkg::CMD_TOGGLE) begin
      // backward search, newest entry first
      for (i = set_count - 1; i >= 0; i--)
        if (hit < 0 && set_keys[i] == key) hit = i;
      if (hit >= 0) begin
        r.position = hit[ast_pkg::POS_W-1:0];
        if (cmd == ast_pkg::CMD_INSERT) begin
          r.status = ast_pkg::ST_PRESENT;
        end else begin
          for (i = hit; i < set_count - 1; i++) set_keys[i] = set_keys[i+1];
          set_count--;
          r.status = ast_pkg::ST_REMOVED;
        end
      end else if (set_count >= ast_pkg::CAPACITY_DEF) begin
        r.status = ast_pkg::ST_FULL;
        r.position = '0;
      end else begin
        set_keys[set_count] = key;
        r.position = set_count[ast_pkg::POS_W-1:0];
        set_count++;
        r.status = ast_pkg::ST_INSERTED;
      end
    end else begin
      r.position = ridx;
      if (int'(ridx) < set_count) begin
        r.status = ast_pkg::ST_READ_OK;
        r.entry_key = set_keys[ridx];
      end else begin
        r.status = ast_pkg::ST_READ_OOR;
      end
    end
    r.entry_count = set_count[ast_pkg::COUNT_W-1:0];
    return r;
  endfunction

  // Stimulus: directed table, then random bursts that fill, drain or mix
  initial begin
    int                         n;
    int                         mode;
    int                         burst_left;
    int                         roll;
    int                         stored_pct;
    logic [31:0]                rnd;
    logic [ast_pkg::CMD_W-1:0]  c;
    logic [ast_pkg::KEY_W-1:0]  k;
    logic [ast_pkg::RIDX_W-1:0] r;
    ast_pkg::res_t              predicted;
    mode = MODE_MIX;
    burst_left = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (n = 0; n < NUM_DIRECTED + NUM_RANDOM; n++) begin
      no_idle = (n >= NUM_DIRECTED + 150) && (n < NUM_DIRECTED + 260);
      while (!no_idle && $urandom_range(99) < 19) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
      if (n < NUM_DIRECTED) begin
        c = directed_rows[n].cmd;
        k = directed_rows[n].key;
        r = directed_rows[n].ridx;
      end else begin
        if (burst_left == 0) begin
          mode = $urandom_range(MODE_MIX);
          burst_left = (mode == MODE_FILL) ? $urandom_range(30, 80) : $urandom_range(20, 60);
        end
        burst_left--;
        roll = $urandom_range(99);
        case (mode)
          MODE_FILL: begin
            c = (roll < 70) ? ast_pkg::CMD_INSERT :
                (roll < 80) ? ast_pkg::CMD_TOGGLE : ast_pkg::CMD_READ;
            stored_pct = 20;
          end
          MODE_DRAIN: begin
            c = (roll < 70) ? ast_pkg::CMD_TOGGLE :
                (roll < 80) ? ast_pkg::CMD_INSERT : ast_pkg::CMD_READ;
            stored_pct = 80;
          end
          default: begin
            rnd = $urandom_range(CMD_SPARE);
            c = rnd[ast_pkg::CMD_W-1:0];
            stored_pct = 45;
          end
        endcase
        if (c == ast_pkg::CMD_READ && $urandom_range(9) == 0) c = CMD_SPARE;
        // key: one already held, a fresh one, or an extreme
        roll = $urandom_range(99);
        if (roll < stored_pct && set_count > 0) begin
          k = set_keys[$urandom_range(set_count - 1)];
        end else if (roll < 92) begin
          rnd = $urandom();
          k = rnd[ast_pkg::KEY_W-1:0];
        end else begin
          rnd = $urandom_range(1);
          k = ($urandom_range(1) == 1) ? '1 : rnd[ast_pkg::KEY_W-1:0];
        end
        if (set_count > 0 && $urandom_range(99) < 70)
          rnd = $urandom_range(set_count - 1);
        else
          rnd = $urandom_range(31);
        r = rnd[ast_pkg::RIDX_W-1:0];
      end
      in_valid <= 1'b1;
      in_cmd <= c;
      in_key <= k;
      in_read_index <= r;
      do @(posedge clk); while (in_stall);
      predicted = apply_to_set(c, k, r);
      if (n < NUM_DIRECTED && directed_rows[n].typed)
        pending_results.push_back(directed_rows[n].res);
      else
        pending_results.push_back(predicted);
    end
    in_valid <= 1'b0;
    no_idle = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Result side stalls at random, except in the no-idle window
  always @(posedge clk) begin
    if (!rst_n || no_idle) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < 19);
    end
  end

  // Compare each result transfer with the oldest expectation
  always @(posedge clk) begin
    ast_pkg::res_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result status=%0d pos=%0d key=%h count=%0d", $time,
                 out_status, out_position, out_entry_key, out_entry_count);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_status !== want.status) begin
          $display("%0t: status expected %0d, got %0d", $time, want.status, out_status);
          fail_count++;
        end
        if (out_position !== want.position) begin
          $display("%0t: position expected %0d, got %0d", $time, want.position, out_position);
          fail_count++;
        end
        if (out_entry_key !== want.entry_key) begin
          $display("%0t: entry_key expected %h, got %h", $time, want.entry_key, out_entry_key);
          fail_count++;
        end
        if (out_entry_count !== want.entry_count) begin
          $display("%0t: entry_count expected %0d, got %0d", $time, want.entry_count,
                   out_entry_count);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: too long without any transfer on either side
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_MAX) begin
      $display("%0t: timeout, %0d results outstanding", $time, pending_results.size());
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule

### array_set_toggle_store.f
hdl/ast_pkg.sv
hdl/ast_key_ram.sv
hdl/ast_seq.sv
hdl/array_set_toggle_store.sv
tb/sv/tb_top.sv
